[rtl/c8ie_pkg.sv]
// ----------------------------------------------------------------------------
// c8ie_pkg: shared constants for the chip-8 instruction execute block
// Opcode groups, alu sub-codes, status codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ie_pkg;

  // widths of the architectural state
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned INSTR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned NUM_VREGS = 16;
  localparam int unsigned STATUS_W = 2;

  // status codes reported with each result
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_OP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

  // top opcode nibble
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEI   = 4'h3;
  localparam logic [3:0] OP_SNEI  = 4'h4;
  localparam logic [3:0] OP_SER   = 4'h5;
  localparam logic [3:0] OP_LDI   = 4'h6;
  localparam logic [3:0] OP_ADDI  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNER  = 4'h9;
  localparam logic [3:0] OP_LDIDX = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;

  // full return opcode
  localparam logic [INSTR_W-1:0] INSTR_RET = 16'h00EE;

  // alu sub-codes (low nibble of 8xyN)
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // flag register and reset values
  localparam logic [REG_IDX_W-1:0] REG_VF = 4'hF;
  localparam logic [REG_IDX_W-1:0] REG_V0 = 4'h0;
  localparam logic [ADDR_W-1:0] PC_RST = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP = 12'd2;

endpackage

`default_nettype wire

[rtl/c8ie_ram.sv]
// ----------------------------------------------------------------------------
// c8ie_ram: generic single-write, single-read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/chip8_instruction_execute_top.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top: chip-8 instruction executor
// Runs one 16-bit opcode per beat against the kept cpu state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries an opcode and a random byte.
//   Result channel (out_valid / out_stall) returns one beat per opcode with
//   the new pc, the index register, the v register write and a status code.
//   cfg_we / cfg_wdata load the start address; the pc takes it at once.
//   The opcode and the v register file read land in the input register at
//   the accept edge, and execute runs from there into the result register.
//   Throughput is one opcode per cycle while out_stall is low; the register
//   file read and the single execute stage set that figure, with the
//   written value forwarded to the following opcode.
//   Reset clears the v registers (through valid bits), the index register
//   and the stack pointer, and loads pc with 0x200. Stack contents are not
//   cleared. When the receiver stalls, the result is held and one more
//   opcode may wait in the input register; then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_execute_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_instruction,
  input  wire logic [7:0]  in_random_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_next_pc,
  output logic [11:0]      out_index_value,
  output logic             out_reg_written,
  output logic [3:0]       out_reg_number,
  output logic [7:0]       out_reg_value,
  output logic [1:0]       out_status
);

  import c8ie_pkg::*;

  localparam int unsigned STK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned STK_LW = $clog2(STACK_DEPTH + 1);

  // handshake
  logic in_accept;
  logic exec_fire;

  // input register
  logic                 in_valid_r;
  logic [INSTR_W-1:0]   instr_r;
  logic [DATA_W-1:0]    rnd_r;

  // architectural state
  logic [ADDR_W-1:0]    pc_r, pc_nxt;
  logic [ADDR_W-1:0]    index_r, index_nxt;
  logic [DATA_W-1:0]    vf_r, vf_nxt;
  logic [DATA_W-1:0]    v0_r, v0_nxt;
  logic [NUM_VREGS-1:0] vld_r, vld_nxt;
  logic [STK_LW-1:0]    level_r, level_nxt;
  logic [ADDR_W-1:0]    top_r, top_nxt;

  // register file access
  logic [REG_IDX_W-1:0] rd_x_sel, rd_y_sel;
  logic [DATA_W-1:0]    ram_x_rd, ram_y_rd;
  logic                 vr_we;
  logic [REG_IDX_W-1:0] vr_waddr;
  logic [DATA_W-1:0]    vr_wdata;
  logic                 fwd_x_r, fwd_y_r;
  logic [DATA_W-1:0]    fwd_data_r;
  logic                 vld_x_r, vld_y_r;

  // return stack access
  logic                 stk_we;
  logic [STK_AW-1:0]    stk_waddr;
  logic [STK_LW-1:0]    stk_rd_lvl;
  logic [ADDR_W-1:0]    stk_rd;

  // decoded fields
  logic [3:0]           op_hi;
  logic [REG_IDX_W-1:0] op_x, op_y;
  logic [3:0]           op_n;
  logic [ADDR_W-1:0]    op_nnn;
  logic [DATA_W-1:0]    op_kk;
  logic [DATA_W-1:0]    vx, vy;

  // execute results
  logic [ADDR_W-1:0]    pc_inc;
  logic [ADDR_W-1:0]    npc;
  logic                 skip;
  logic                 wr;
  logic                 flag_op;
  logic [DATA_W-1:0]    val;
  logic [DATA_W-1:0]    flag;
  logic [STATUS_W-1:0]  status;
  logic [DATA_W:0]      sum;
  logic [ADDR_W-1:0]    final_pc;

  // result register
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_pc_r;
  logic [ADDR_W-1:0]    out_index_r;
  logic                 out_wr_r;
  logic [REG_IDX_W-1:0] out_num_r;
  logic [DATA_W-1:0]    out_val_r;
  logic [STATUS_W-1:0]  out_status_r;

  // beat flow: the input register empties whenever the result slot is free
  assign exec_fire = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !exec_fire;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (exec_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      instr_r <= in_instruction;
      rnd_r   <= in_random_byte;
    end
  end

  // register file read addresses follow the incoming beat, else hold
  assign rd_x_sel = in_accept ? in_instruction[11:8] : instr_r[11:8];
  assign rd_y_sel = in_accept ? in_instruction[7:4]  : instr_r[7:4];

  c8ie_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_VREGS)
  ) u_vreg_x (
    .clk     (clk),
    .wr_en   (vr_we),
    .wr_addr (vr_waddr),
    .wr_data (vr_wdata),
    .rd_addr (rd_x_sel),
    .rd_data (ram_x_rd)
  );

  c8ie_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_VREGS)
  ) u_vreg_y (
    .clk     (clk),
    .wr_en   (vr_we),
    .wr_addr (vr_waddr),
    .wr_data (vr_wdata),
    .rd_addr (rd_y_sel),
    .rd_data (ram_y_rd)
  );

  // forward a write landing in the same edge as the read, and capture valid bits
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_x_r    <= vr_we && (vr_waddr == in_instruction[11:8]);
      fwd_y_r    <= vr_we && (vr_waddr == in_instruction[7:4]);
      fwd_data_r <= vr_wdata;
      vld_x_r    <= vld_r[in_instruction[11:8]];
      vld_y_r    <= vld_r[in_instruction[7:4]];
    end
  end

  // field decode
  assign op_hi  = instr_r[15:12];
  assign op_x   = instr_r[11:8];
  assign op_y   = instr_r[7:4];
  assign op_n   = instr_r[3:0];
  assign op_nnn = instr_r[ADDR_W-1:0];
  assign op_kk  = instr_r[DATA_W-1:0];

  // operand select: vf lives in flops, others in the ram copies
  always_comb begin
    if (op_x == REG_VF) begin
      vx = vf_r;
    end else if (fwd_x_r) begin
      vx = fwd_data_r;
    end else if (vld_x_r) begin
      vx = ram_x_rd;
    end else begin
      vx = '0;
    end
    if (op_y == REG_VF) begin
      vy = vf_r;
    end else if (fwd_y_r) begin
      vy = fwd_data_r;
    end else if (vld_y_r) begin
      vy = ram_y_rd;
    end else begin
      vy = '0;
    end
  end

  // return stack storage; read port tracks the entry under the top
  assign stk_rd_lvl = (exec_fire ? level_nxt : level_r) - STK_LW'(2);

  c8ie_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (pc_inc),
    .rd_addr (stk_rd_lvl[STK_AW-1:0]),
    .rd_data (stk_rd)
  );

  assign pc_inc    = pc_r + PC_STEP;
  assign sum       = {1'b0, vx} + {1'b0, vy};
  assign stk_waddr = level_r[STK_AW-1:0];

  // execute
  always_comb begin
    npc       = pc_inc;
    skip      = 1'b0;
    wr        = 1'b0;
    flag_op   = 1'b0;
    val       = '0;
    flag      = '0;
    status    = ST_OK;
    index_nxt = index_r;
    level_nxt = level_r;
    top_nxt   = top_r;
    stk_we    = 1'b0;
    case (op_hi)
      OP_SYS: begin
        if (instr_r == INSTR_RET) begin
          if (level_r == '0) begin
            status = ST_UNDERFLOW;
          end else begin
            npc       = top_r;
            level_nxt = level_r - STK_LW'(1);
            top_nxt   = stk_rd;
          end
        end else begin
          status = ST_BAD_OP;
        end
      end
      OP_JP: npc = op_nnn;
      OP_CALL: begin
        if (level_r >= STK_LW'(STACK_DEPTH)) begin
          status = ST_OVERFLOW;
        end else begin
          stk_we    = exec_fire;
          level_nxt = level_r + STK_LW'(1);
          top_nxt   = pc_inc;
          npc       = op_nnn;
        end
      end
      OP_SEI:  skip = (vx == op_kk);
      OP_SNEI: skip = (vx != op_kk);
      OP_SER: begin
        if (op_n != 4'h0) begin
          status = ST_BAD_OP;
        end else begin
          skip = (vx == vy);
        end
      end
      OP_SNER: begin
        if (op_n != 4'h0) begin
          status = ST_BAD_OP;
        end else begin
          skip = (vx != vy);
        end
      end
      OP_LDI: begin
        wr  = 1'b1;
        val = op_kk;
      end
      OP_ADDI: begin
        wr  = 1'b1;
        val = vx + op_kk;
      end
      OP_ALU: begin
        case (op_n)
          ALU_LD: begin
            wr  = 1'b1;
            val = vy;
          end
          ALU_OR: begin
            wr  = 1'b1;
            val = vx | vy;
          end
          ALU_AND: begin
            wr  = 1'b1;
            val = vx & vy;
          end
          ALU_XOR: begin
            wr  = 1'b1;
            val = vx ^ vy;
          end
          ALU_ADD: begin
            wr      = 1'b1;
            flag_op = 1'b1;
            val     = sum[DATA_W-1:0];
            flag    = DATA_W'(sum[DATA_W]);
          end
          ALU_SUB: begin
            wr      = 1'b1;
            flag_op = 1'b1;
            val     = vx - vy;
            flag    = DATA_W'(vx >= vy);
          end
          ALU_SHR: begin
            wr      = 1'b1;
            flag_op = 1'b1;
            val     = vx >> 1;
            flag    = DATA_W'(vx[0]);
          end
          ALU_SUBN: begin
            wr      = 1'b1;
            flag_op = 1'b1;
            val     = vy - vx;
            flag    = DATA_W'(vy >= vx);
          end
          ALU_SHL: begin
            wr      = 1'b1;
            flag_op = 1'b1;
            val     = vx << 1;
            flag    = DATA_W'(vx[DATA_W-1]);
          end
          default: status = ST_BAD_OP;
        endcase
      end
      OP_LDIDX: index_nxt = op_nnn;
      OP_JPV0:  npc = op_nnn + ADDR_W'(v0_r);
      OP_RND: begin
        wr  = 1'b1;
        val = rnd_r & op_kk;
      end
      default: status = ST_BAD_OP;
    endcase
  end

  assign final_pc = skip ? (npc + PC_STEP) : npc;

  // register file write: vf kept in flops, v0 in flops and the ram copies, others go to the ram copies
  assign vr_we    = exec_fire && wr && (op_x != REG_VF);
  assign vr_waddr = op_x;
  assign vr_wdata = val;

  always_comb begin
    vf_nxt  = vf_r;
    v0_nxt  = v0_r;
    vld_nxt = vld_r;
    if (exec_fire && wr) begin
      if (flag_op) begin
        vf_nxt = flag;
      end else if (op_x == REG_VF) begin
        vf_nxt = val;
      end
      if (op_x == REG_V0) begin
        v0_nxt = val;
      end
      if (op_x != REG_VF) begin
        vld_nxt[op_x] = 1'b1;
      end
    end
  end

  // pc: reset value, config load, or execute
  always_comb begin
    pc_nxt = pc_r;
    if (cfg_we) begin
      pc_nxt = cfg_wdata;
    end else if (exec_fire) begin
      pc_nxt = final_pc;
    end
  end

  // architectural state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_RST;
      index_r <= '0;
      vf_r    <= '0;
      v0_r    <= '0;
      vld_r   <= '0;
      level_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      vf_r  <= vf_nxt;
      v0_r  <= v0_nxt;
      vld_r <= vld_nxt;
      if (exec_fire) begin
        index_r <= index_nxt;
        level_r <= level_nxt;
      end
    end
  end

  // stack top copy, payload only
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      top_r <= top_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_pc_r     <= final_pc;
      out_index_r  <= index_nxt;
      out_wr_r     <= wr;
      out_num_r    <= !wr ? '0 : (flag_op ? REG_VF : op_x);
      out_val_r    <= !wr ? '0 : (flag_op ? flag : val);
      out_status_r <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_index_value = out_index_r;
  assign out_reg_written = out_wr_r;
  assign out_reg_number  = out_num_r;
  assign out_reg_value   = out_val_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire
